### src/ghash_pkg.sv
// Shared types and constants for the GHASH GF(2^128) accumulator.
`default_nettype none

package ghash_pkg;

    // Field element and half-block widths.
    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int PROD_W  = 2 * BLOCK_W - 1;

    // Low terms of the field polynomial x^128 + x^7 + x^2 + x + 1, in normal bit order.
    // In the GCM reflected bit order this is the familiar 0xe1 leading byte.
    localparam logic [7:0] RED_POLY = 8'h87;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBKEY_LOW  = 1'b1;

    // A 128-bit block, GCM bit 0 (MSB of byte 0) held in bit 127.
    typedef logic [BLOCK_W-1:0] t_block;

endpackage : ghash_pkg

`default_nettype wire

### src/ghash_gfmul.sv
// Combinational GF(2^128) multiplier in GCM bit order.
`default_nettype none

module ghash_gfmul (
    input  wire ghash_pkg::t_block i_x,
    input  wire ghash_pkg::t_block i_y,
    output ghash_pkg::t_block      o_z
);

    localparam int BW = ghash_pkg::BLOCK_W;
    localparam int PW = ghash_pkg::PROD_W;

    logic [BW-1:0]      w_a;
    logic [BW-1:0]      w_b;
    logic [PW-1:0]      w_prod;
    logic [BW+5:0]      w_fold1;
    logic [PW-BW-1:0]   w_hi1;
    logic [5:0]         w_hi2;
    logic [BW-1:0]      w_fold2;

    // Reflect both operands so that bit i is the coefficient of x^i.
    always_comb begin
        for (int i = 0; i < BW; i++) begin
            w_a[i] = i_x[BW-1-i];
            w_b[i] = i_y[BW-1-i];
        end
    end

    // Carry-less product: each output coefficient is an independent XOR of AND terms.
    always_comb begin
        for (int k = 0; k < PW; k++) begin
            w_prod[k] = 1'b0;
            for (int i = 0; i < BW; i++) begin
                if ((k - i >= 0) && (k - i < BW)) begin
                    w_prod[k] = w_prod[k] ^ (w_a[i] & w_b[k-i]);
                end
            end
        end
    end

    // First fold: the terms of degree 128 and up come back as hi * (x^7 + x^2 + x + 1).
    always_comb begin
        w_hi1   = w_prod[PW-1:BW];
        w_fold1 = {6'd0, w_prod[BW-1:0]};
        for (int t = 0; t < 8; t++) begin
            if (ghash_pkg::RED_POLY[t]) begin
                w_fold1 = w_fold1 ^ ({7'd0, w_hi1} << t);
            end
        end
    end

    // Second fold covers the few bits that the first fold pushed past degree 127.
    always_comb begin
        w_hi2   = w_fold1[BW+5:BW];
        w_fold2 = w_fold1[BW-1:0];
        for (int t = 0; t < 8; t++) begin
            if (ghash_pkg::RED_POLY[t]) begin
                w_fold2 = w_fold2 ^ ({{(BW-6){1'b0}}, w_hi2} << t);
            end
        end
    end

    // Reflect the reduced result back into GCM bit order.
    always_comb begin
        for (int i = 0; i < BW; i++) begin
            o_z[BW-1-i] = w_fold2[i];
        end
    end

endmodule : ghash_gfmul

`default_nettype wire

### src/ghash_gf128_accumulator.sv
// Top level of the GHASH accumulator: input stage, GF(2^128) update and result register.
// Throughput is one 128-bit block per cycle while a finished hash is not stalled in the result register;
// the accumulator is updated by one combinational GF(2^128) multiply by the subkey.
// A hash passes through the input register and then the result register before it
// appears on the master side.
// Reset (i_rst_n low, synchronous) clears the subkey, the accumulator and all valid flags.
`default_nettype none

module ghash_gf128_accumulator (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write port.
    input  wire                                  i_cfg_we,
    input  wire [ghash_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [ghash_pkg::HALF_W-1:0]          i_cfg_data,
    // Input blocks.
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [ghash_pkg::BLOCK_W-1:0]         s_axis_tdata,  // block_high, block_low
    input  wire                                  s_axis_tuser,  // first_block
    input  wire                                  s_axis_tlast,  // last_block
    // Hash results.
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [ghash_pkg::BLOCK_W-1:0]        m_axis_tdata   // hash_high, hash_low
);

    localparam int HW = ghash_pkg::HALF_W;

    logic [HW-1:0]       r_key_high;
    logic [HW-1:0]       r_key_low;
    logic                r_in_valid;
    ghash_pkg::t_block   r_in_blk;
    logic                r_in_first;
    logic                r_in_last;
    ghash_pkg::t_block   r_acc;
    logic                r_out_valid;
    ghash_pkg::t_block   r_out_data;

    ghash_pkg::t_block   w_sum;
    ghash_pkg::t_block   w_prod;
    logic                w_adv;

    // Subkey registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ghash_pkg::CFG_SUBKEY_HIGH: r_key_high <= i_cfg_data;
                ghash_pkg::CFG_SUBKEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The input stage moves on unless it holds a last block and the result register is stuck.
    assign w_adv         = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_blk   <= {s_axis_tdata[HW-1:0], s_axis_tdata[2*HW-1:HW]};
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    // Absorb the block, starting from zero on the first block of a message.
    assign w_sum = r_in_first ? r_in_blk : (r_acc ^ r_in_blk);

    ghash_gfmul u_gfmul (
        .i_x (w_sum),
        .i_y ({r_key_high, r_key_low}),
        .o_z (w_prod)
    );

    // Accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_adv) begin
            r_acc <= w_prod;
        end
    end

    // Result register, loaded on the transfer of a last block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_data <= w_prod;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_data[HW-1:0], r_out_data[2*HW-1:HW]};

    // A last block waiting on a stalled result must hold off new input.
    a_last_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a last block is stalled");

    // An emitted hash equals the accumulator it was taken from.
    a_out_matches_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_out_valid && (r_out_data == r_acc)))
        else $error("result register differs from accumulator");

    // With a zero subkey every product, and so the accumulator, is zero.
    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_key_high == '0) && (r_key_low == '0)) |=> (r_acc == '0))
        else $error("nonzero product with zero subkey");

endmodule : ghash_gf128_accumulator

`default_nettype wire
